/* hw/rtl/hsl_to_rgb_converter_top_assert.svh */
// Assertion macros for the HSL to RGB converter.
// Each macro checks an implication on the rising edge of the given clock,
// held off while the active-low reset is asserted.
`ifndef HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define H2R_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("h2r: same-cycle check failed");
`define H2R_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("h2r: next-cycle check failed");
`else
`define H2R_ASSERT_NOW(lbl, ck, rstn, ante, cons)
`define H2R_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

/* hw/rtl/h2r_pkg.sv */
package h2r_pkg;

	// Unsigned Q0.16 fractions; 1.0 is 65536, so a fraction needs 17 bits.
	localparam int FRAC_W     = 17;
	localparam int HUE_FRAC_W = 16;

	localparam logic [16:0] FRAC_ONE        = 17'd65536;
	localparam logic [16:0] FRAC_HALF       = 17'd32768;
	localparam logic [16:0] FRAC_THIRD      = 17'd21845;
	localparam logic [16:0] FRAC_TWO_THIRDS = 17'd43690;
	// 65536 - one third, used to wrap a negative channel hue
	localparam logic [16:0] FRAC_WRAP_THIRD = 17'd43691;

	localparam logic [7:0]  PCT_MAX    = 8'd100;
	localparam logic [8:0]  DEG_FULL   = 9'd360;
	// floor(hue / 360) == (hue * HUE_RECIP) >> 24 for every 16-bit hue
	localparam logic [15:0] HUE_RECIP  = 16'd46604;
	// floor(deg * 65536 / 360) == (deg * DEG_SCALE) >> 24 for deg < 360
	localparam logic [31:0] DEG_SCALE  = 32'd3054198967;
	// floor(pct * 65536 / 100) == (pct * PCT_RECIP) >> 16 for pct <= 100
	localparam logic [25:0] PCT_RECIP  = 26'd42949673;

	localparam int H2R_QUEUE_DEPTH = 4;

	// One classified colour waiting between front and back
	typedef struct packed {
		logic                  grey;
		logic [HUE_FRAC_W-1:0] hue_frac;
		logic [FRAC_W-1:0]     sat_frac;
		logic [FRAC_W-1:0]     light_frac;
	} h2r_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} h2r_qstat_t;

	// Piece of the piecewise-linear channel curve
	typedef enum logic [1:0] {
		SEG_RISE,
		SEG_TOP,
		SEG_FALL,
		SEG_LOW
	} h2r_seg_t;

	// Scale a fraction to 0..255, truncating and saturating
	function automatic logic [7:0] frac_to_byte(input logic [17:0] v);
		logic [25:0] x;
		x = {v, 8'b0} - 26'(v);
		return (x[25:24] != 2'b00) ? 8'hFF : x[23:16];
	endfunction

endpackage

/* hw/rtl/hsl_to_rgb_converter_top.sv */
// HSL to RGB colour converter. Each transfer on the input channel carries a
// hue in degrees (any 16-bit value, taken modulo 360) and a saturation and
// lightness in percent (values above 100 act as 100); each produces exactly
// one transfer on the output channel with the packed colour, red in bits
// 23:16, green in 15:8 and blue in 7:0, in input order. One colour is taken
// every clock cycle when the output side keeps ready high. On its way from
// input transfer to output valid a colour passes three front stages (hue
// reduction and scaling), the queue and six back stages (temperatures,
// curve segment, ramp multiply, select, byte scaling). The queue,
// QUEUE_DEPTH entries deep, lets the front keep accepting colours after
// the output side stalls; input ready drops only when the queue is full
// and the front stages are all occupied. No configuration and no state
// beyond the pipeline.

`include "hsl_to_rgb_converter_top_assert.svh"

module hsl_to_rgb_converter_top import h2r_pkg::*; #(
	parameter int QUEUE_DEPTH = H2R_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  lightness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] packed_colour
);

	// Front to queue
	logic       fq_valid;
	h2r_item_t  fq_item;
	// Queue to back
	h2r_item_t  qb_item;
	logic       qb_ready;
	h2r_qstat_t q_stat;

	logic push, pop;

	h2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.lightness  (lightness),
		.item_valid (fq_valid),
		.item       (fq_item),
		.item_ready (!q_stat.full)
	);

	h2r_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_item  (fq_item),
		.pop_ready  (qb_ready),
		.pop_item   (qb_item),
		.stat       (q_stat)
	);

	h2r_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (!q_stat.empty),
		.item          (qb_item),
		.item_ready    (qb_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packed_colour (packed_colour)
	);

	// Queue transfers as seen from outside the queue
	assign push = fq_valid && !q_stat.full;
	assign pop  = qb_ready && !q_stat.empty;

	// Full and empty are never seen together
	`H2R_ASSERT_NOW(a_stat_excl, clk, arst_n, 1'b1, !(q_stat.full && q_stat.empty))
	// Input ready drops only once the queue has filled up
	`H2R_ASSERT_NOW(a_stall_full, clk, arst_n, !in_ready, q_stat.full)
	// A push into an empty queue with no pop leaves it holding an entry
	`H2R_ASSERT_NEXT(a_push_fill, clk, arst_n, push && !pop && q_stat.empty, !q_stat.empty)
	// A pop from a full queue with no push frees a slot
	`H2R_ASSERT_NEXT(a_pop_room, clk, arst_n, pop && !push && q_stat.full, !q_stat.full)

endmodule

/* hw/rtl/h2r_queue.sv */
module h2r_queue import h2r_pkg::*; #(
	parameter int DEPTH = H2R_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  h2r_item_t  push_item,
	input  logic       pop_ready,
	output h2r_item_t  pop_item,
	output h2r_qstat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	h2r_item_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign push       = push_valid && !stat.full;
	assign pop        = pop_ready && !stat.empty;
	assign pop_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/h2r_front.sv */
module h2r_front import h2r_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [15:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  lightness,
	output logic       item_valid,
	output h2r_item_t  item,
	input  logic       item_ready
);

	logic en1, en2, en3;

	logic              v_s1, v_s2, v_s3;
	logic [15:0]       hue_s1;
	logic [7:0]        quot_s1;
	logic [FRAC_W-1:0] sat_s1, light_s1, sat_s2, light_s2;
	logic              grey_s1, grey_s2;
	logic [8:0]        deg_s2;
	h2r_item_t         item_s3;

	logic [6:0]  sat_clip, light_clip;
	logic [31:0] quot_prod;
	logic [32:0] sat_prod, light_prod;
	logic [16:0] quot_deg;
	logic [15:0] deg_rem;
	logic [40:0] hue_prod;

	assign en3      = !v_s3 || item_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign item_valid = v_s3;
	assign item       = item_s3;

	// Stage 1: clip percentages, scale to fractions, estimate hue / 360
	always_comb begin
		sat_clip   = (saturation > PCT_MAX) ? PCT_MAX[6:0] : saturation[6:0];
		light_clip = (lightness > PCT_MAX) ? PCT_MAX[6:0] : lightness[6:0];
		sat_prod   = 33'(sat_clip) * 33'(PCT_RECIP);
		light_prod = 33'(light_clip) * 33'(PCT_RECIP);
		quot_prod  = 32'(hue) * 32'(HUE_RECIP);
	end

	// Stage 2: remainder in degrees
	always_comb begin
		quot_deg = 17'(quot_s1) * 17'(DEG_FULL);
		deg_rem  = hue_s1 - quot_deg[15:0];
	end

	// Stage 3: degrees to a hue fraction
	assign hue_prod = 41'(deg_s2) * 41'(DEG_SCALE);

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			hue_s1   <= hue;
			quot_s1  <= quot_prod[31:24];
			sat_s1   <= sat_prod[32:16];
			light_s1 <= light_prod[32:16];
			grey_s1  <= (sat_clip == '0);
		end
		if (en2 && v_s1) begin
			deg_s2   <= deg_rem[8:0];
			sat_s2   <= sat_s1;
			light_s2 <= light_s1;
			grey_s2  <= grey_s1;
		end
		if (en3 && v_s2) begin
			item_s3.grey       <= grey_s2;
			item_s3.hue_frac   <= hue_prod[39:24];
			item_s3.sat_frac   <= sat_s2;
			item_s3.light_frac <= light_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

endmodule

/* hw/rtl/h2r_back.sv */
module h2r_back import h2r_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  h2r_item_t   item,
	output logic        item_ready,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] packed_colour
);

	localparam int NCH = 3;

	logic en1, en2, en3, en4, en5, en6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1
	logic [FRAC_W-1:0]     prod_ls_s1, sat_s1, light_s1;
	logic [HUE_FRAC_W-1:0] hue_s1;
	logic                  grey_s1;
	// stage 2
	logic [FRAC_W-1:0] t1_s2, light_s2;
	logic [FRAC_W-1:0] chue_s2 [NCH];
	logic              grey_s2;
	// stage 3
	logic [FRAC_W-1:0] t1_s3, t2_s3, diff_s3, light_s3;
	h2r_seg_t          seg_s3 [NCH];
	logic [15:0]       mult_s3 [NCH];
	logic              grey_s3;
	// stage 4
	logic [FRAC_W-1:0] t1_s4, t2_s4, light_s4;
	logic [FRAC_W-1:0] ramp_s4 [NCH];
	h2r_seg_t          seg_s4 [NCH];
	logic              grey_s4;
	// stage 5
	logic [17:0] val_s5 [NCH];
	// stage 6 (output register)
	logic [23:0] colour_s6;

	logic [33:0]       ls_prod;
	logic [17:0]       t1_raw, sum_ls, light_x2;
	logic [FRAC_W-1:0] t1_sat, t2_c, diff_c;
	logic [17:0]       hue_up;
	logic [FRAC_W-1:0] chue_c [NCH];
	h2r_seg_t          seg_c [NCH];
	logic [15:0]       mult_c [NCH];
	logic [19:0]       six_c;
	logic [18:0]       fall_c;
	logic [32:0]       ramp_prod [NCH];
	logic [17:0]       val_c [NCH];

	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign item_ready    = en1;
	assign out_valid     = v_s6;
	assign packed_colour = colour_s6;

	// Stage 1: lightness times saturation
	assign ls_prod = 34'(item.light_frac) * 34'(item.sat_frac);

	// Stage 2: upper temperature and the three shifted hues
	always_comb begin
		sum_ls = 18'(light_s1) + 18'(sat_s1);
		if (light_s1 < FRAC_HALF) begin
			t1_raw = 18'(light_s1) + 18'(prod_ls_s1);
		end else begin
			t1_raw = (sum_ls > 18'(prod_ls_s1)) ? sum_ls - 18'(prod_ls_s1) : '0;
		end
		t1_sat = (t1_raw > 18'(FRAC_ONE)) ? FRAC_ONE : t1_raw[16:0];

		hue_up     = 18'(hue_s1) + 18'(FRAC_THIRD);
		chue_c[0]  = (hue_up > 18'(FRAC_ONE)) ? 17'(hue_up - 18'(FRAC_ONE)) : hue_up[16:0];
		chue_c[1]  = 17'(hue_s1);
		chue_c[2]  = (17'(hue_s1) < FRAC_THIRD) ? 17'(hue_s1) + FRAC_WRAP_THIRD
		                                        : 17'(hue_s1) - FRAC_THIRD;
	end

	// Stage 3: lower temperature, spread, and curve segment per channel
	always_comb begin
		light_x2 = {light_s2, 1'b0};
		t2_c     = (light_x2 > 18'(t1_s2)) ? 17'(light_x2 - 18'(t1_s2)) : '0;
		diff_c   = (t1_s2 > t2_c) ? t1_s2 - t2_c : '0;
		six_c    = '0;
		fall_c   = '0;
		for (int ch = 0; ch < NCH; ch++) begin
			six_c  = 20'(chue_s2[ch]) * 20'd6;
			fall_c = (chue_s2[ch] <= FRAC_TWO_THIRDS)
			       ? 19'(FRAC_TWO_THIRDS - chue_s2[ch]) * 19'd6 : '0;
			if (six_c < 20'(FRAC_ONE)) begin
				seg_c[ch]  = SEG_RISE;
				mult_c[ch] = six_c[15:0];
			end else if (chue_s2[ch] < FRAC_HALF) begin
				seg_c[ch]  = SEG_TOP;
				mult_c[ch] = '0;
			end else if (chue_s2[ch] <= FRAC_TWO_THIRDS) begin
				seg_c[ch]  = SEG_FALL;
				mult_c[ch] = fall_c[15:0];
			end else begin
				seg_c[ch]  = SEG_LOW;
				mult_c[ch] = '0;
			end
		end
	end

	// Stage 4: ramp products
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			ramp_prod[ch] = 33'(diff_s3) * 33'(mult_s3[ch]);
		end
	end

	// Stage 5: pick the channel value, or the lightness for grey
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			unique case (seg_s4[ch])
				SEG_RISE: val_c[ch] = 18'(t2_s4) + 18'(ramp_s4[ch]);
				SEG_TOP:  val_c[ch] = 18'(t1_s4);
				SEG_FALL: val_c[ch] = 18'(t2_s4) + 18'(ramp_s4[ch]);
				SEG_LOW:  val_c[ch] = 18'(t2_s4);
				default:  val_c[ch] = 18'(t2_s4);
			endcase
			if (grey_s4) begin
				val_c[ch] = 18'(light_s4);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && item_valid) begin
			prod_ls_s1 <= ls_prod[32:16];
			sat_s1     <= item.sat_frac;
			light_s1   <= item.light_frac;
			hue_s1     <= item.hue_frac;
			grey_s1    <= item.grey;
		end
		if (en2 && v_s1) begin
			t1_s2    <= t1_sat;
			light_s2 <= light_s1;
			grey_s2  <= grey_s1;
			for (int ch = 0; ch < NCH; ch++) begin
				chue_s2[ch] <= chue_c[ch];
			end
		end
		if (en3 && v_s2) begin
			t1_s3    <= t1_s2;
			t2_s3    <= t2_c;
			diff_s3  <= diff_c;
			light_s3 <= light_s2;
			grey_s3  <= grey_s2;
			for (int ch = 0; ch < NCH; ch++) begin
				seg_s3[ch]  <= seg_c[ch];
				mult_s3[ch] <= mult_c[ch];
			end
		end
		if (en4 && v_s3) begin
			t1_s4    <= t1_s3;
			t2_s4    <= t2_s3;
			light_s4 <= light_s3;
			grey_s4  <= grey_s3;
			for (int ch = 0; ch < NCH; ch++) begin
				seg_s4[ch]  <= seg_s3[ch];
				ramp_s4[ch] <= ramp_prod[ch][32:16];
			end
		end
		if (en5 && v_s4) begin
			for (int ch = 0; ch < NCH; ch++) begin
				val_s5[ch] <= val_c[ch];
			end
		end
		if (en6 && v_s5) begin
			colour_s6 <= {frac_to_byte(val_s5[0]), frac_to_byte(val_s5[1]),
			              frac_to_byte(val_s5[2])};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= item_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

endmodule

/* dv/tb_hsl_to_rgb_converter_top.sv */
module tb_hsl_to_rgb_converter_top;
	import h2r_pkg::*;

	// One colour request waiting to be driven. When hold_for_drain is set,
	// the driver keeps it back until every predicted colour has come out.
	typedef struct {
		bit [15:0] hue;
		bit [7:0]  sat;
		bit [7:0]  light;
		bit        hold_for_drain;
	} hsl_req_t;

	localparam int RANDOM_REQS   = 700;
	localparam int SETTLE_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] hue = '0;
	logic [7:0]  saturation = '0;
	logic [7:0]  lightness = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [23:0] packed_colour;

	hsl_req_t    pending_hsl[$];
	logic [23:0] predicted_rgb[$];
	bit          hsl_taken = 1'b0;
	int          fail_count = 0;
	int          gap_left = 0;
	int          burst_left = 0;
	int          ready_run = 0;

	hsl_to_rgb_converter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.hue           (hue),
		.saturation    (saturation),
		.lightness     (lightness),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.packed_colour (packed_colour)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Colour predictor: Q0.16 fractions, every product truncated
	// ------------------------------------------------------------------

	// Multiply two fractions and drop the 16 fraction bits
	function automatic int unsigned frac_product(int unsigned a, int unsigned b);
		return int'((64'(a) * 64'(b)) >> 16);
	endfunction

	// Scale a fraction to 0..255, truncating and saturating
	function automatic bit [7:0] byte_of_frac(int unsigned v);
		int unsigned r;
		r = int'((64'(v) * 64'd255) >> 16);
		return (r > 255) ? 8'hFF : r[7:0];
	endfunction

	// Percent to fraction; anything above 100 acts as 100
	function automatic int unsigned pct_frac(bit [7:0] p);
		int unsigned v;
		v = (p > PCT_MAX) ? int'(PCT_MAX) : int'(p);
		return (v * int'(FRAC_ONE)) / int'(PCT_MAX);
	endfunction

	// Level of one channel for its shifted hue on the piecewise-linear curve
	function automatic bit [7:0] channel_level(int c, int unsigned t1, int unsigned t2);
		int unsigned d;
		int unsigned cu;
		int unsigned v;
		d = (t1 > t2) ? t1 - t2 : 0;
		if (c < 0) begin
			c += int'(FRAC_ONE);
		end else if (c > int'(FRAC_ONE)) begin
			c -= int'(FRAC_ONE);
		end
		cu = c;
		if (6 * cu < int'(FRAC_ONE)) begin
			v = t2 + frac_product(d, 6 * cu);
		end else if (2 * cu < int'(FRAC_ONE)) begin
			v = t1;
		end else if (3 * cu < 2 * int'(FRAC_ONE)) begin
			v = t2 + frac_product(d,
				6 * ((cu <= int'(FRAC_TWO_THIRDS)) ? int'(FRAC_TWO_THIRDS) - cu : 0));
		end else begin
			v = t2;
		end
		return byte_of_frac(v);
	endfunction

	function automatic logic [23:0] hsl_to_packed_rgb(bit [15:0] h_deg, bit [7:0] s_pct,
			bit [7:0] l_pct);
		int unsigned deg;
		int          h;
		int unsigned s;
		int unsigned l;
		int unsigned ls;
		int unsigned t1;
		int unsigned t2;
		bit [7:0]    grey;
		deg = h_deg % int'(DEG_FULL);
		h   = (deg * int'(FRAC_ONE)) / int'(DEG_FULL);
		s   = pct_frac(s_pct);
		l   = pct_frac(l_pct);
		// No saturation: every channel carries the lightness alone
		if (s == 0) begin
			grey = byte_of_frac(l);
			return {grey, grey, grey};
		end
		ls = frac_product(l, s);
		if (l < int'(FRAC_HALF)) begin
			t1 = l + ls;
		end else begin
			t1 = (l + s > ls) ? l + s - ls : 0;
		end
		if (t1 > int'(FRAC_ONE)) t1 = int'(FRAC_ONE);
		t2 = (2 * l > t1) ? 2 * l - t1 : 0;
		return {channel_level(h + int'(FRAC_THIRD), t1, t2),
			channel_level(h, t1, t2),
			channel_level(h - int'(FRAC_THIRD), t1, t2)};
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic queue_hsl(bit [15:0] h, bit [7:0] s, bit [7:0] l, bit drain);
		hsl_req_t r;
		r.hue = h;
		r.sat = s;
		r.light = l;
		r.hold_for_drain = drain;
		pending_hsl.push_back(r);
	endtask

	// Pick a percent: mostly in range, with the clip, zero and full mixed in
	function automatic bit [7:0] pick_pct();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd100;
			2: return 8'($urandom_range(101, 255));
			default: return 8'($urandom_range(1, 99));
		endcase
	endfunction

	initial begin
		bit [15:0] h;

		// Directed: primaries and secondaries at full saturation, half light
		queue_hsl(16'd0,   8'd100, 8'd50, 1'b0);
		queue_hsl(16'd60,  8'd100, 8'd50, 1'b0);
		queue_hsl(16'd120, 8'd100, 8'd50, 1'b0);
		queue_hsl(16'd180, 8'd100, 8'd50, 1'b0);
		queue_hsl(16'd240, 8'd100, 8'd50, 1'b0);
		queue_hsl(16'd300, 8'd100, 8'd50, 1'b0);
		// Hue wrap: last degree, a full turn and the largest hue; then 30 degrees
		queue_hsl(16'd359,   8'd100, 8'd50, 1'b0);
		queue_hsl(16'd360,   8'd100, 8'd50, 1'b0);
		queue_hsl(16'hFFFF,  8'd100, 8'd50, 1'b0);
		queue_hsl(16'd30,    8'd100, 8'd50, 1'b0);
		// Grey: no saturation, lightness at both ends and clipped
		queue_hsl(16'd200, 8'd0, 8'd0,   1'b0);
		queue_hsl(16'd200, 8'd0, 8'd50,  1'b0);
		queue_hsl(16'd200, 8'd0, 8'd100, 1'b0);
		queue_hsl(16'd200, 8'd0, 8'hFF,  1'b0);
		// Lightness either side of one half selects the temperature formula
		queue_hsl(16'd90,  8'd70, 8'd49, 1'b0);
		queue_hsl(16'd90,  8'd70, 8'd50, 1'b0);
		queue_hsl(16'd90,  8'd70, 8'd51, 1'b0);
		// Black and white at full saturation
		queue_hsl(16'd45,  8'd100, 8'd0,   1'b0);
		queue_hsl(16'd45,  8'd100, 8'd100, 1'b0);
		// Saturation and lightness above 100 act as 100; then small and mixed values
		queue_hsl(16'd270, 8'd101, 8'd40,  1'b0);
		queue_hsl(16'd270, 8'hFF,  8'hFF,  1'b0);
		queue_hsl(16'd150, 8'd1,   8'd1,   1'b0);
		queue_hsl(16'd15,  8'd50,  8'd200, 1'b0);
		queue_hsl(16'hAAAA, 8'h55, 8'hAA,  1'b0);

		// Random: first one held until the directed part has fully drained,
		// another hold midway
		for (int i = 0; i < RANDOM_REQS; i++) begin
			case ($urandom_range(0, 3))
				0: h = 16'($urandom_range(0, 65535));
				default: h = 16'($urandom_range(0, 359));
			endcase
			queue_hsl(h, pick_pct(), pick_pct(), (i == 0) || (i == RANDOM_REQS / 2));
		end

		// Hold reset, then release it on a falling edge
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait until every request has been transferred, then until every
		// predicted colour has come out, then let the pipeline settle
		do @(posedge clk); while (pending_hsl.size() != 0 || in_valid);
		while (predicted_rgb.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Guard against a hung handshake
	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Driver: present requests in bursts, advance on the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		hsl_req_t r;
		bit       nv;
		if (arst_n && (!in_valid || hsl_taken)) begin
			nv = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_hsl.size() != 0 &&
					!(pending_hsl[0].hold_for_drain && predicted_rgb.size() != 0)) begin
				r = pending_hsl.pop_front();
				nv = 1'b1;
				hue        <= r.hue;
				saturation <= r.sat;
				lightness  <= r.light;
				// End of a burst: draw the next gap and burst length
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
				end else begin
					burst_left--;
				end
			end
			in_valid <= nv;
		end
	end

	// Receiver: ready runs with stalls of random length between them
	always @(negedge clk) begin
		bit rdy;
		rdy = out_ready;
		if (!arst_n) begin
			rdy = 1'b0;
		end else if (ready_run == 0) begin
			if (out_ready && $urandom_range(0, 2) != 0) begin
				rdy = 1'b0;
				ready_run = $urandom_range(1, 10);
			end else begin
				rdy = 1'b1;
				ready_run = $urandom_range(1, 40);
			end
		end else begin
			ready_run--;
		end
		out_ready <= rdy;
	end

	// ------------------------------------------------------------------
	// Monitor: predict on each input transfer, check each output transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic [23:0] want;
		hsl_taken <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted_rgb.push_back(hsl_to_packed_rgb(hue, saturation, lightness));
			end
			if (out_valid && out_ready) begin
				if (predicted_rgb.size() == 0) begin
					fail_count++;
					$display("%0t: colour %06h with none expected", $time,
						packed_colour);
				end else begin
					want = predicted_rgb.pop_front();
					if (packed_colour !== want) begin
						fail_count++;
						$display("%0t: packed_colour expected %06h actual %06h",
							$time, want, packed_colour);
					end
				end
			end
		end
	end

endmodule
